/* design/cubic_hermite_segment_interp_unit_assert.svh */
// Assertion macros shared by the interpolator RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef CUBIC_HERMITE_SEGMENT_INTERP_UNIT_ASSERT_SVH
`define CUBIC_HERMITE_SEGMENT_INTERP_UNIT_ASSERT_SVH

// same-cycle implication
`define CHS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/chs_pkg.sv */
// Shared types, widths and arithmetic helpers of the cubic Hermite interpolator.
// No dependencies.
package chs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int TW        = 31;
	localparam int DP_W      = DW + 1;
	localparam int DIV_W     = DP_W + FRAC_BITS + 1;
	localparam int DIV_STEPS = DIV_W;
	localparam int UW        = 33;
	localparam int PROD_W    = DW + TW;
	localparam int ACC_W     = 64;
	localparam int MAC_STAGES = 3;
	localparam int IN_W      = 192;
	localparam int OUT_W     = 96;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef struct packed {
		logic signed [DW-1:0]     p0;
		logic signed [DW-1:0]     v0;
		logic signed [DW-1:0]     v1;
		logic signed [DP_W-1:0]   dp;
		logic signed [PROD_W-1:0] prod0;
		logic signed [PROD_W-1:0] prod1;
		logic [TW-1:0]            t;
		logic [TW-1:0]            dur;
		logic                     zero;
	} chs_side_t;

	typedef struct packed {
		logic [TW-1:0]    rem;
		logic [DIV_W-1:0] nq;
	} chs_div_lane_t;

	typedef struct packed {
		logic                 zero;
		logic [TW-1:0]        t;
		logic signed [DW-1:0] vel;
		logic signed [DW-1:0] pos;
	} chs_res_t;

	function automatic chs_div_lane_t div_step(chs_div_lane_t x, logic [TW-1:0] d);
		logic [TW:0]   cand;
		chs_div_lane_t r;
		cand = {x.rem, x.nq[DIV_W-1]};
		if (cand >= {1'b0, d}) begin
			r.rem = TW'(cand - {1'b0, d});
			r.nq  = {x.nq[DIV_W-2:0], 1'b1};
		end else begin
			r.rem = cand[TW-1:0];
			r.nq  = {x.nq[DIV_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] shr_round(logic signed [PROD_W-1:0] x);
		logic [PROD_W-1:0]       m;
		logic [PROD_W-1:0]       r;
		logic signed [ACC_W-1:0] s;
		m = x[PROD_W-1] ? (~x + PROD_W'(1)) : x;
		r = (m + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		s = signed'(ACC_W'(r));
		return x[PROD_W-1] ? -s : s;
	endfunction

	function automatic logic [DW-1:0] sat32(logic signed [ACC_W-1:0] x);
		logic [DW-1:0] r;
		if (x > SAT_MAX) begin
			r = SAT_MAX[DW-1:0];
		end else if (x < SAT_MIN) begin
			r = SAT_MIN[DW-1:0];
		end else begin
			r = x[DW-1:0];
		end
		return r;
	endfunction

endpackage

/* design/chs_prep.sv */
// Input stage: clamp, difference, duration products and divider operands.
// Depends on chs_pkg.
module chs_prep (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [chs_pkg::DW-1:0] p0,
	input  logic signed [chs_pkg::DW-1:0] v0,
	input  logic signed [chs_pkg::DW-1:0] p1,
	input  logic signed [chs_pkg::DW-1:0] v1,
	input  logic [chs_pkg::TW-1:0]       dur,
	input  logic signed [chs_pkg::DW-1:0] qt,
	output logic                         vld_s1,
	output chs_pkg::chs_side_t           side_s1,
	output chs_pkg::chs_div_lane_t       lane_u_s1,
	output chs_pkg::chs_div_lane_t       lane_d_s1
);

	logic [chs_pkg::TW-1:0]          tc;
	logic signed [chs_pkg::DP_W-1:0] dp;
	logic [chs_pkg::DP_W-1:0]        dp_mag;
	logic signed [chs_pkg::DW-1:0]   dur_s;
	logic signed [2*chs_pkg::DW-1:0] pr0;
	logic signed [2*chs_pkg::DW-1:0] pr1;
	chs_pkg::chs_side_t              side;
	chs_pkg::chs_div_lane_t          lu;
	chs_pkg::chs_div_lane_t          ld;

	always_comb begin
		if (qt[chs_pkg::DW-1]) begin
			tc = '0;
		end else if (qt[chs_pkg::TW-1:0] > dur) begin
			tc = dur;
		end else begin
			tc = qt[chs_pkg::TW-1:0];
		end
		dp     = chs_pkg::DP_W'(p1) - chs_pkg::DP_W'(p0);
		dp_mag = dp[chs_pkg::DP_W-1] ? (~dp + chs_pkg::DP_W'(1)) : dp;
		dur_s  = signed'({1'b0, dur});
		pr0    = v0 * dur_s;
		pr1    = v1 * dur_s;

		side.p0    = p0;
		side.v0    = v0;
		side.v1    = v1;
		side.dp    = dp;
		side.prod0 = pr0[chs_pkg::PROD_W-1:0];
		side.prod1 = pr1[chs_pkg::PROD_W-1:0];
		side.t     = tc;
		side.dur   = dur;
		side.zero  = (dur == '0);

		lu.rem = chs_pkg::TW'(tc >> (chs_pkg::DIV_W - chs_pkg::DW));
		lu.nq  = chs_pkg::DIV_W'({tc, {chs_pkg::DW{1'b0}}})
			+ chs_pkg::DIV_W'(dur[chs_pkg::TW-1:1]);
		ld.rem = '0;
		ld.nq  = chs_pkg::DIV_W'({dp_mag, {chs_pkg::FRAC_BITS{1'b0}}})
			+ chs_pkg::DIV_W'(dur[chs_pkg::TW-1:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= side;
			lane_u_s1 <= lu;
			lane_d_s1 <= ld;
		end
	end

endmodule

/* design/chs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing the divisor.
// Depends on chs_pkg.
module chs_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  chs_pkg::chs_side_t     side_in,
	input  chs_pkg::chs_div_lane_t lane_u_in,
	input  chs_pkg::chs_div_lane_t lane_d_in,
	output logic                   out_valid,
	output chs_pkg::chs_side_t     side_out,
	output logic [chs_pkg::DIV_W-1:0] q_u,
	output logic [chs_pkg::DIV_W-1:0] q_d
);

	logic                   vld_s    [chs_pkg::DIV_STEPS];
	chs_pkg::chs_side_t     side_s   [chs_pkg::DIV_STEPS];
	chs_pkg::chs_div_lane_t lane_u_s [chs_pkg::DIV_STEPS];
	chs_pkg::chs_div_lane_t lane_d_s [chs_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < chs_pkg::DIV_STEPS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < chs_pkg::DIV_STEPS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0]   <= side_in;
			lane_u_s[0] <= chs_pkg::div_step(lane_u_in, side_in.dur);
			lane_d_s[0] <= chs_pkg::div_step(lane_d_in, side_in.dur);
			for (int k = 1; k < chs_pkg::DIV_STEPS; k++) begin
				side_s[k]   <= side_s[k-1];
				lane_u_s[k] <= chs_pkg::div_step(lane_u_s[k-1], side_s[k-1].dur);
				lane_d_s[k] <= chs_pkg::div_step(lane_d_s[k-1], side_s[k-1].dur);
			end
		end
	end

	assign out_valid = vld_s[chs_pkg::DIV_STEPS-1];
	assign side_out  = side_s[chs_pkg::DIV_STEPS-1];
	assign q_u       = lane_u_s[chs_pkg::DIV_STEPS-1].nq;
	assign q_d       = lane_d_s[chs_pkg::DIV_STEPS-1].nq;

endmodule

/* design/chs_mac.sv */
// Three-stage term + x*u/2^32 with rounding, u unsigned Q1.32 up to one.
// Depends on chs_pkg.
module chs_mac (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [chs_pkg::ACC_W-1:0] x,
	input  logic signed [chs_pkg::ACC_W-1:0] term,
	input  logic [chs_pkg::UW-1:0]          u,
	output logic signed [chs_pkg::ACC_W-1:0] y
);

	logic [chs_pkg::ACC_W-1:0]        m;
	logic [chs_pkg::ACC_W:0]          rsum;
	logic                             neg_s1;
	logic [chs_pkg::ACC_W:0]          pl_s1;
	logic [chs_pkg::ACC_W:0]          ph_s1;
	logic signed [chs_pkg::ACC_W-1:0] term_s1;
	logic signed [chs_pkg::ACC_W-1:0] r_s2;
	logic signed [chs_pkg::ACC_W-1:0] term_s2;
	logic signed [chs_pkg::ACC_W-1:0] y_s3;

	always_comb begin
		m    = x[chs_pkg::ACC_W-1] ? (~x + chs_pkg::ACC_W'(1)) : x;
		rsum = ph_s1 + (pl_s1 >> 32) + (chs_pkg::ACC_W+1)'(pl_s1[31]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= x[chs_pkg::ACC_W-1];
			pl_s1   <= m[31:0] * u;
			ph_s1   <= m[chs_pkg::ACC_W-1:32] * u;
			term_s1 <= term;

			r_s2    <= neg_s1 ? -signed'(rsum[chs_pkg::ACC_W-1:0])
				: signed'(rsum[chs_pkg::ACC_W-1:0]);
			term_s2 <= term_s1;

			y_s3    <= term_s2 + r_s2;
		end
	end

	assign y = y_s3;

endmodule

/* design/chs_eval.sv */
// Coefficient forming, Horner evaluation of position and velocity, saturation.
// Depends on chs_pkg and chs_mac.
module chs_eval (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  chs_pkg::chs_side_t        side,
	input  logic [chs_pkg::DIV_W-1:0] q_u,
	input  logic [chs_pkg::DIV_W-1:0] q_d,
	output logic                      out_valid,
	output chs_pkg::chs_res_t         res
);

	localparam int HL = 3 * chs_pkg::MAC_STAGES;

	logic signed [chs_pkg::ACC_W-1:0] dq;

	logic                              vld_s1;
	logic [chs_pkg::UW-1:0]            u_s1;
	logic signed [chs_pkg::ACC_W-1:0]  d_s1;
	logic signed [chs_pkg::ACC_W-1:0]  a0_s1;
	logic signed [chs_pkg::ACC_W-1:0]  a1_s1;
	logic signed [chs_pkg::DP_W-1:0]   dp_s1;
	logic signed [chs_pkg::DW-1:0]     p0_s1;
	logic signed [chs_pkg::DW-1:0]     v0_s1;
	logic signed [chs_pkg::DW-1:0]     v1_s1;
	logic [chs_pkg::TW-1:0]            t_s1;
	logic                              zero_s1;

	logic                              vld_s2;
	logic [chs_pkg::UW-1:0]            u_s2;
	logic signed [chs_pkg::ACC_W-1:0]  b_s2;
	logic signed [chs_pkg::ACC_W-1:0]  c_s2;
	logic signed [chs_pkg::ACC_W-1:0]  a0_s2;
	logic signed [chs_pkg::ACC_W-1:0]  e1_s2;
	logic signed [chs_pkg::ACC_W-1:0]  e2_s2;
	logic signed [chs_pkg::DW-1:0]     p0_s2;
	logic signed [chs_pkg::DW-1:0]     v0_s2;
	logic [chs_pkg::TW-1:0]            t_s2;
	logic                              zero_s2;

	logic                              vld_s [HL];
	logic [chs_pkg::UW-1:0]            u_s   [2*chs_pkg::MAC_STAGES];
	logic signed [chs_pkg::ACC_W-1:0]  a0_s  [chs_pkg::MAC_STAGES];
	logic signed [chs_pkg::ACC_W-1:0]  vel_s [chs_pkg::MAC_STAGES];
	logic signed [chs_pkg::DW-1:0]     p0_s  [HL];
	logic signed [chs_pkg::DW-1:0]     v0_s  [HL];
	logic [chs_pkg::TW-1:0]            t_s   [HL];
	logic                              zero_s[HL];

	logic signed [chs_pkg::ACC_W-1:0] pos1_y, pos2_y, pos3_y, vel1_y, vel2_y;

	logic                             vld_sf;
	chs_pkg::chs_res_t                res_sf;

	assign dq = signed'(chs_pkg::ACC_W'(q_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < HL; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s[0] <= vld_s2;
			for (int k = 1; k < HL; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			vld_sf <= vld_s[HL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= q_u[chs_pkg::UW-1:0];
			d_s1    <= side.dp[chs_pkg::DP_W-1] ? -dq : dq;
			a0_s1   <= chs_pkg::shr_round(side.prod0);
			a1_s1   <= chs_pkg::shr_round(side.prod1);
			dp_s1   <= side.dp;
			p0_s1   <= side.p0;
			v0_s1   <= side.v0;
			v1_s1   <= side.v1;
			t_s1    <= side.t;
			zero_s1 <= side.zero;

			u_s2    <= u_s1;
			b_s2    <= 64'sd3 * chs_pkg::ACC_W'(dp_s1) - 64'sd2 * a0_s1 - a1_s1;
			c_s2    <= -64'sd2 * chs_pkg::ACC_W'(dp_s1) + a0_s1 + a1_s1;
			a0_s2   <= a0_s1;
			e1_s2   <= 64'sd6 * d_s1 - 64'sd4 * chs_pkg::ACC_W'(v0_s1)
				- 64'sd2 * chs_pkg::ACC_W'(v1_s1);
			e2_s2   <= -64'sd6 * d_s1 + 64'sd3 * chs_pkg::ACC_W'(v0_s1)
				+ 64'sd3 * chs_pkg::ACC_W'(v1_s1);
			p0_s2   <= p0_s1;
			v0_s2   <= v0_s1;
			t_s2    <= t_s1;
			zero_s2 <= zero_s1;

			u_s[0] <= u_s2;
			for (int k = 1; k < 2*chs_pkg::MAC_STAGES; k++) begin
				u_s[k] <= u_s[k-1];
			end
			a0_s[0]  <= a0_s2;
			vel_s[0] <= vel2_y;
			for (int k = 1; k < chs_pkg::MAC_STAGES; k++) begin
				a0_s[k]  <= a0_s[k-1];
				vel_s[k] <= vel_s[k-1];
			end
			p0_s[0]   <= p0_s2;
			v0_s[0]   <= v0_s2;
			t_s[0]    <= t_s2;
			zero_s[0] <= zero_s2;
			for (int k = 1; k < HL; k++) begin
				p0_s[k]   <= p0_s[k-1];
				v0_s[k]   <= v0_s[k-1];
				t_s[k]    <= t_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end

			res_sf.zero <= zero_s[HL-1];
			res_sf.t    <= t_s[HL-1];
			res_sf.pos  <= zero_s[HL-1] ? p0_s[HL-1] : signed'(chs_pkg::sat32(pos3_y));
			res_sf.vel  <= zero_s[HL-1] ? v0_s[HL-1]
				: signed'(chs_pkg::sat32(vel_s[chs_pkg::MAC_STAGES-1]));
		end
	end

	chs_mac u_pos1 (.clk(clk), .en(en), .x(c_s2), .term(b_s2), .u(u_s2), .y(pos1_y));
	chs_mac u_pos2 (.clk(clk), .en(en), .x(pos1_y), .term(a0_s[chs_pkg::MAC_STAGES-1]),
		.u(u_s[chs_pkg::MAC_STAGES-1]), .y(pos2_y));
	chs_mac u_pos3 (.clk(clk), .en(en), .x(pos2_y),
		.term(chs_pkg::ACC_W'(p0_s[2*chs_pkg::MAC_STAGES-1])),
		.u(u_s[2*chs_pkg::MAC_STAGES-1]), .y(pos3_y));
	chs_mac u_vel1 (.clk(clk), .en(en), .x(e2_s2), .term(e1_s2), .u(u_s2), .y(vel1_y));
	chs_mac u_vel2 (.clk(clk), .en(en), .x(vel1_y),
		.term(chs_pkg::ACC_W'(v0_s[chs_pkg::MAC_STAGES-1])),
		.u(u_s[chs_pkg::MAC_STAGES-1]), .y(vel2_y));

	assign out_valid = vld_sf;
	assign res       = res_sf;

endmodule

/* design/cubic_hermite_segment_interp_unit.sv */
// Top level of the cubic Hermite segment interpolator: stream ports and output skid.
// Depends on chs_pkg, chs_prep, chs_div, chs_eval and the assertion header.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata  192b: p0, v0, p1, v1, T, query time
//   m_*      out  m_tvalid/m_tready  m_tdata  96b: position, velocity, clamped time
//                                    m_tuser  1b: zero duration
//
// One transaction per cycle in and out while the output is not stalled; the
// 50-stage divider forms the normalized time and the mean velocity.
// arst_n clears all valid bits; payload registers are not reset.
// A stalled output fills the skid register, then the whole pipeline holds.
`include "cubic_hermite_segment_interp_unit_assert.svh"

module cubic_hermite_segment_interp_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// start_position, start_velocity, end_position, end_velocity,
	// segment_duration (31b), query_time, zero pad
	input  logic [chs_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// interp_position, interp_velocity, clamped_time (31b), zero pad
	output logic [chs_pkg::OUT_W-1:0]  m_tdata,
	// zero_duration_flag
	output logic [0:0]                 m_tuser
);

	logic                   en;
	logic                   prep_v;
	chs_pkg::chs_side_t     prep_side;
	chs_pkg::chs_div_lane_t prep_lu;
	chs_pkg::chs_div_lane_t prep_ld;
	logic                   div_v;
	chs_pkg::chs_side_t     div_side;
	logic [chs_pkg::DIV_W-1:0] div_qu;
	logic [chs_pkg::DIV_W-1:0] div_qd;
	logic                   ev_v;
	chs_pkg::chs_res_t      ev_res;
	logic                   out_v_q;
	logic                   skid_v_q;
	chs_pkg::chs_res_t      out_q;
	chs_pkg::chs_res_t      skid_q;

	assign en       = ~skid_v_q;
	assign s_tready = en;

	chs_prep u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid),
		.p0(s_tdata[31:0]), .v0(s_tdata[63:32]), .p1(s_tdata[95:64]),
		.v1(s_tdata[127:96]), .dur(s_tdata[158:128]), .qt(s_tdata[190:159]),
		.vld_s1(prep_v), .side_s1(prep_side), .lane_u_s1(prep_lu), .lane_d_s1(prep_ld)
	);

	chs_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(prep_v),
		.side_in(prep_side), .lane_u_in(prep_lu), .lane_d_in(prep_ld),
		.out_valid(div_v), .side_out(div_side), .q_u(div_qu), .q_d(div_qd)
	);

	chs_eval u_eval (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(div_v),
		.side(div_side), .q_u(div_qu), .q_d(div_qd),
		.out_valid(ev_v), .res(ev_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (ev_v) begin
				if (!out_v_q || m_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ev_v) begin
				if (!out_v_q || m_tready) begin
					out_q <= ev_res;
				end else begin
					skid_q <= ev_res;
				end
			end
		end else if (m_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_q.t, out_q.vel, out_q.pos};
	assign m_tuser  = out_q.zero;

	`CHS_ASSERT_SAME(a_skid_needs_out, skid_v_q, out_v_q, "skid holds data with output empty")
	`CHS_ASSERT_NEXT(a_full_holds_input, skid_v_q && !m_tready, !s_tready, "input taken while full")
	`CHS_ASSERT_SAME(a_zero_time, m_tvalid && m_tuser[0], m_tdata[94:64] == '0, "zero T time")

endmodule

/* tb/sv/cubic_hermite_segment_interp_checker.sv */
// Checker for the cubic Hermite segment interpolator: predicts each result from the accepted
// input transaction and compares it with the output stream in order.
// Depends on chs_pkg for widths.
module cubic_hermite_segment_interp_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [chs_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [chs_pkg::OUT_W-1:0] m_tdata,
	input  logic [0:0]                m_tuser,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [chs_pkg::DW-1:0] pos;
		logic [chs_pkg::DW-1:0] vel;
		logic [chs_pkg::TW-1:0] ct;
		logic                   zero;
	} interp_point_t;

	interp_point_t point_q[$];

	function automatic logic [63:0] magnitude(longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint with_sign(logic [63:0] m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// x * u / 2^32, rounded half away from zero
	function automatic longint scale_by_u(longint x, logic [63:0] u);
		logic [63:0] m, hi, lo, pl, r;
		m  = magnitude(x);
		hi = m >> 32;
		lo = m & 64'hFFFF_FFFF;
		pl = lo * u;
		r  = hi * u + (pl >> 32) + ((pl >> 31) & 64'd1);
		return with_sign(r, x < 0);
	endfunction

	function automatic logic [chs_pkg::DW-1:0] clip32(longint x);
		if (x > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'h8000_0000;
		return x[31:0];
	endfunction

	function automatic interp_point_t hermite_point(logic [chs_pkg::IN_W-1:0] w);
		longint p0, v0, p1, v1, dur, t, dp, a0, a1, b, c, d, e1, e2, pos, vel;
		logic [63:0] u, ud, m;
		interp_point_t r;
		p0  = longint'(signed'(w[31:0]));
		v0  = longint'(signed'(w[63:32]));
		p1  = longint'(signed'(w[95:64]));
		v1  = longint'(signed'(w[127:96]));
		dur = longint'({33'd0, w[158:128]});
		t   = longint'(signed'(w[190:159]));
		if (t < 0)
			t = 0;
		else if (t > dur)
			t = dur;
		if (dur == 0) begin
			r.pos  = p0[31:0];
			r.vel  = v0[31:0];
			r.ct   = '0;
			r.zero = 1'b1;
			return r;
		end
		ud = 64'(dur);
		u  = ((64'(t) << 32) + ud / 2) / ud;
		dp = p1 - p0;
		m  = magnitude(v0 * dur);
		a0 = with_sign((m + (64'd1 << (chs_pkg::FRAC_BITS - 1))) >> chs_pkg::FRAC_BITS, v0 < 0);
		m  = magnitude(v1 * dur);
		a1 = with_sign((m + (64'd1 << (chs_pkg::FRAC_BITS - 1))) >> chs_pkg::FRAC_BITS, v1 < 0);
		b  = 3 * dp - 2 * a0 - a1;
		c  = -2 * dp + a0 + a1;
		pos = p0 + scale_by_u(a0 + scale_by_u(b + scale_by_u(c, u), u), u);
		m  = ((magnitude(dp) << chs_pkg::FRAC_BITS) + ud / 2) / ud;
		d  = with_sign(m, dp < 0);
		e1 = 6 * d - 4 * v0 - 2 * v1;
		e2 = -6 * d + 3 * v0 + 3 * v1;
		vel = v0 + scale_by_u(e1 + scale_by_u(e2, u), u);
		r.pos  = clip32(pos);
		r.vel  = clip32(vel);
		r.ct   = t[chs_pkg::TW-1:0];
		r.zero = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		interp_point_t exp_pt;
		interp_point_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				point_q.push_back(hermite_point(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[94:64], m_tuser[0]};
				if (point_q.size() == 0) begin
					$error("unexpected result transaction %h", m_tdata);
					errors++;
				end else begin
					exp_pt = point_q.pop_front();
					if (got.pos !== exp_pt.pos) begin
						$error("interp_position expected %h actual %h", exp_pt.pos, got.pos);
						errors++;
					end
					if (got.vel !== exp_pt.vel) begin
						$error("interp_velocity expected %h actual %h", exp_pt.vel, got.vel);
						errors++;
					end
					if (got.ct !== exp_pt.ct) begin
						$error("clamped_time expected %h actual %h", exp_pt.ct, got.ct);
						errors++;
					end
					if (got.zero !== exp_pt.zero) begin
						$error("zero_duration_flag expected %b actual %b", exp_pt.zero,
							got.zero);
						errors++;
					end
				end
			end
			pending <= point_q.size();
		end
	end
endmodule

/* tb/sv/tb_cubic_hermite_segment_interp_unit.sv */
// Top of the interpolator testbench: clock, reset, segment stimulus, output back-pressure
// and verdict. Depends on chs_pkg, the RTL and cubic_hermite_segment_interp_checker.
module tb_cubic_hermite_segment_interp_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [chs_pkg::IN_W-1:0]   s_tdata = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [chs_pkg::OUT_W-1:0]  m_tdata;
	logic [0:0]                 m_tuser;
	int                         errors;
	int                         pending;
	int                         send_idle_pct = 0;
	int                         stall_pct = 0;
	bit                         hold_go = 0;
	int                         hold_left = 0;
	longint                     cycles = 0;

	cubic_hermite_segment_interp_unit DUT (.*);

	cubic_hermite_segment_interp_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// output back-pressure; a long hold is counted down here
	always @(negedge clk) begin
		if (hold_go && hold_left == 0) begin
			hold_left = 300;
			hold_go = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = $urandom_range(99) >= stall_pct;
		end
	end

	function automatic logic [chs_pkg::IN_W-1:0] segment_word(logic [31:0] p0,
			logic [31:0] v0, logic [31:0] p1, logic [31:0] v1, logic [30:0] dur,
			logic [31:0] t);
		return {1'b0, t, dur, v1, p1, v0, p0};
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
			2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
			default: return 32'($signed($urandom_range(0, 32'h7FFFFFF)) - 32'sh4000000);
		endcase
	endfunction

	function automatic logic [chs_pkg::IN_W-1:0] rand_segment();
		logic [30:0] dur;
		logic [31:0] t;
		case ($urandom_range(9))
			0: dur = '0;
			1, 2: dur = 31'($urandom);
			3: dur = 31'($urandom_range(1, 16));
			default: dur = 31'($urandom_range(1, 32'h000A_0000));
		endcase
		case ($urandom_range(9))
			0: t = $urandom;
			1: t = 32'(-$signed({1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))}));
			2: t = {1'b0, dur} + 32'($urandom_range(0, 100));
			3: t = {1'b0, dur};
			default: t = $urandom_range(0, {1'b0, dur});
		endcase
		return segment_word(rand_value(), rand_value(), rand_value(), rand_value(), dur, t);
	endfunction

	task automatic send_segment(logic [chs_pkg::IN_W-1:0] w);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_segment(segment_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0, 31'd0, 32'h5));
		send_segment(segment_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 31'd0,
			32'h8000_0000));
		send_segment(segment_word(32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0, 31'h0001_0000,
			32'hFFFF_0000));
		send_segment(segment_word(32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0, 31'h0001_0000,
			32'h0003_0000));
		send_segment(segment_word(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'hFFFF_0000,
			31'h0002_0000, 32'h0002_0000));
		send_segment(segment_word(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'hFFFF_0000,
			31'h0002_0000, 32'h0));
		send_segment(segment_word(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'hFFFF_0000,
			31'h0002_0000, 32'h0001_0000));
		send_segment(segment_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			31'h7FFF_FFFF, 32'h4000_0000));
		send_segment(segment_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			31'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_segment(segment_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF, 32'h2000_0000));
		send_segment(segment_word(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 31'd1, 32'd1));
		send_segment(segment_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			31'd3, 32'd1));
		send_segment(segment_word(32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 31'd1,
			32'h8000_0000));
		send_segment(segment_word(32'h0, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 32'h7FFF_FFFF));
		drain();

		// fill the pipeline against a held-off output
		@(posedge clk) hold_go = 1;
		@(negedge clk);
		repeat (150) send_segment(rand_segment());
		drain();

		send_idle_pct = 80;
		stall_pct = 0;
		repeat (180) send_segment(rand_segment());
		drain();
		send_idle_pct = 0;
		stall_pct = 80;
		repeat (180) send_segment(rand_segment());
		drain();
		send_idle_pct = 37;
		stall_pct = 37;
		repeat (200) send_segment(rand_segment());
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (180) send_segment(rand_segment());
		drain();

		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
